// ===== rtl/core/batch_sorter_ascending_top_macros.svh =====
// assertion helpers used by the sorter controller
`ifndef BATCH_SORTER_ASCENDING_TOP_MACROS_SVH
`define BATCH_SORTER_ASCENDING_TOP_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BSA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// implication checked on every rising clock edge outside reset
`define BSA_ASSERT_IMPL(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

// ===== rtl/core/bsa_pkg.sv =====
package bsa_pkg;

   // batch capacity and widths
   localparam int MAX_ITEMS = 64;
   localparam int VALUE_W   = 32;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_cmd_type;

endpackage

// ===== rtl/core/bsa_cell.sv =====
module bsa_cell
   import bsa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cell_cmd_type              cmd,
   input  logic signed [VALUE_W-1:0] din,
   input  logic signed [VALUE_W-1:0] prev_value,
   input  logic                      prev_valid,
   input  logic                      prev_take,
   input  logic signed [VALUE_W-1:0] next_value,
   input  logic                      next_valid,
   output logic signed [VALUE_W-1:0] value,
   output logic                      valid,
   output logic                      take
);

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      valid_ff, valid_in;

   // an empty cell counts as larger than any value
   assign take = !valid_ff || (din < value_ff);

   // insert: the first taking cell keeps the request, the ones after it
   // receive their left neighbor; shift: everything moves toward cell zero
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.insert) begin
         if (take) begin
            if (prev_take) begin
               value_in = prev_value;
               valid_in = prev_valid;
            end else begin
               value_in = din;
               valid_in = 1'b1;
            end
         end
      end else if (cmd.shift) begin
         value_in = next_value;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

// ===== rtl/core/bsa_ctrl.sv =====
`include "batch_sorter_ascending_top_macros.svh"

module bsa_ctrl
   import bsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_fire,
   input  logic         req_last,
   input  logic         rsp_ready,
   input  logic         second_valid,
   output cell_cmd_type cmd,
   output logic         req_ready,
   output logic         rsp_valid,
   output logic         rsp_last,
   output logic         overflow
);

   typedef enum logic {
      FILL,
      DRAIN
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              dropped_ff;
   logic              full;
   logic              rsp_fire;
   logic              batch_end;
   logic              batch_clear;

   // no handshake on either side while reset is held
   assign full      = (count_ff == CNT_W'(MAX_ITEMS));
   assign req_ready = (state_ff == FILL) && !reset;
   assign rsp_valid = (state_ff == DRAIN) && !reset;
   assign rsp_last  = !second_valid;
   assign overflow  = dropped_ff;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // final result taken, and the empty batch state that must follow it
   assign batch_end   = rsp_fire && rsp_last;
   assign batch_clear = (count_ff == '0) && !dropped_ff;

   // cell commands
   assign cmd.insert = req_fire && !full;
   assign cmd.shift  = rsp_fire;

   // batch state: fill count, drop flag and emit phase
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FILL;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            FILL: begin
               if (req_fire) begin
                  if (full) begin
                     dropped_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
                  if (req_last) begin
                     state_ff <= DRAIN;
                  end
               end
            end
            DRAIN: begin
               if (batch_end) begin
                  state_ff   <= FILL;
                  count_ff   <= '0;
                  dropped_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= FILL;
            end
         endcase
      end
   end

   `BSA_ASSERT(a_count_bound, count_ff <= CNT_W'(MAX_ITEMS), "fill count above capacity")
   `BSA_ASSERT_IMPL(a_drop_full, dropped_ff, full, "drop flag set while store not full")
   `BSA_ASSERT_IMPL(a_drain_clears, batch_end, ##1 batch_clear && req_ready, "batch not cleared")
   `BSA_ASSERT_IMPL(a_drain_nonempty, rsp_valid, count_ff != '0, "emitting from an empty batch")
   `BSA_ASSERT_IMPL(a_single_cmd, cmd.insert, !cmd.shift, "insert and shift together")

endmodule

// ===== rtl/core/batch_sorter_ascending_top.sv =====
// channel   dir  fields (low bit up)             handshake
// req       in   tdata: value[31:0]; tlast: last  req_tvalid / req_tready
// rsp       out  tdata: value_res[31:0];          rsp_tvalid / rsp_tready
//                tlast: last_res; tuser: overflow
//
// a request is taken every cycle while the batch fills; each request is
// registered into its sorted slot of the cell row, or dropped and flagged
// as overflow once the row is full; the closing request turns the row into
// a shift register: one result per cycle from cell zero while rsp_tready
// is high, and req_tready stays low until the last result is taken
// rsp_tready low freezes the row; results hold until taken
// reset (synchronous, active high) empties every cell and the fill count
module batch_sorter_ascending_top
   import bsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,    // value[31:0]
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,    // value_res[31:0]
   output logic         rsp_tlast,
   output logic [0:0]   rsp_tuser     // overflow
);

   cell_cmd_type              cmd;
   logic signed [VALUE_W-1:0] cell_value [MAX_ITEMS];
   logic                      cell_valid [MAX_ITEMS];
   logic                      cell_take  [MAX_ITEMS];
   logic signed [VALUE_W-1:0] din;
   logic                      req_fire;
   logic                      overflow;

   assign din      = req_tdata;
   assign req_fire = req_tvalid && req_tready;

   // controller
   bsa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .req_last     (req_tlast),
      .rsp_ready    (rsp_tready),
      .second_valid (cell_valid[1]),
      .cmd          (cmd),
      .req_ready    (req_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_last     (rsp_tlast),
      .overflow     (overflow)
   );

   // row of sorting cells, smallest value in cell zero
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_value, next_value;
      logic                      prev_valid, prev_take, next_valid;

      if (i == 0) begin : g_head
         assign prev_value = '0;
         assign prev_valid = 1'b0;
         assign prev_take  = 1'b0;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_valid = cell_valid[i-1];
         assign prev_take  = cell_take[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign next_value = '0;
         assign next_valid = 1'b0;
      end else begin : g_link
         assign next_value = cell_value[i+1];
         assign next_valid = cell_valid[i+1];
      end

      bsa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .din        (din),
         .prev_value (prev_value),
         .prev_valid (prev_valid),
         .prev_take  (prev_take),
         .next_value (next_value),
         .next_valid (next_valid),
         .value      (cell_value[i]),
         .valid      (cell_valid[i]),
         .take       (cell_take[i])
      );
   end

   // results come straight from cell zero
   assign rsp_tdata    = cell_value[0];
   assign rsp_tuser[0] = overflow;

endmodule
